/* rtl/tlpq_pkg.sv */
`default_nettype none
package tlpq_pkg;

   localparam int FIELD_ID_W = 16;

   // command codes, the three request codes double as queue levels
   localparam logic [1:0] CMD_REQ_HIGH   = 2'd0;
   localparam logic [1:0] CMD_REQ_MIDDLE = 2'd1;
   localparam logic [1:0] CMD_REQ_LOW    = 2'd2;
   localparam logic [1:0] CMD_SERVICE    = 2'd3;

   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_DROPPED  = 2'd1;
   localparam logic [1:0] ST_SERVED   = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   localparam logic [1:0] LVL_HIGH   = 2'd0;
   localparam logic [1:0] LVL_MIDDLE = 2'd1;
   localparam logic [1:0] LVL_LOW    = 2'd2;

   localparam int NUM_LEVELS = 3;

   typedef struct packed {
      logic       load;
      logic       push;
      logic       drop;
      logic       none_left;
      logic       pop;
      logic [1:0] pop_level;
      logic       promote;
      logic       capture;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       tgt_full;
      logic       high_empty;
      logic       middle_empty;
      logic       low_empty;
   } dp_stat_type;

endpackage
`default_nettype wire

/* rtl/tlpq_req_if.sv */
`default_nettype none
interface tlpq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] request_id;

   modport source (output valid, output command, output request_id, input ready);
   modport sink (input valid, input command, input request_id, output ready);
endinterface
`default_nettype wire

/* rtl/tlpq_rsp_if.sv */
`default_nettype none
interface tlpq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] served_id;
   logic [1:0]  served_level;

   modport source (output valid, output status, output served_id, output served_level,
                   input ready);
   modport sink (input valid, input status, input served_id, input served_level,
                 output ready);
endinterface
`default_nettype wire

/* rtl/three_level_priority_queue_promote_core.sv */
// channel   dir  words                                     handshake
// req_ch    in   command, request_id                       valid / ready
// rsp_ch    out  status, served_id, served_level           valid / ready
//
// one word in flight at a time; ready is high only while the core is idle
// request: accept, a decide state, then the result is valid in the response state
// service: accept, decide, a fetch state for the queue ram read, then result valid
// the registered ram read of each queue fifo is what the fetch state waits for
// reset clears control state, pointers and counts only, queue rams are not cleared
// a stalled result holds the core until it is taken
`default_nettype none
module three_level_priority_queue_promote_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tlpq_req_if.sink    req_ch,
   tlpq_rsp_if.source  rsp_ch
);

   tlpq_pkg::ctrl_cmd_type cmd;
   tlpq_pkg::dp_stat_type  stat;

   tlpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tlpq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_command      (req_ch.command),
      .req_request_id   (req_ch.request_id),
      .rsp_status       (rsp_ch.status),
      .rsp_served_id    (rsp_ch.served_id),
      .rsp_served_level (rsp_ch.served_level)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_ch.valid && req_ch.ready))
      else $error("result pending while new word accepted");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != tlpq_pkg::ST_SERVED |->
         rsp_ch.served_id == 16'd0 && rsp_ch.served_level == tlpq_pkg::LVL_HIGH)
      else $error("non-served result carries id or level");

   a_decide_gap: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !rsp_ch.valid)
      else $error("result valid right after accept");

endmodule
`default_nettype wire

/* rtl/tlpq_ram.sv */
`default_nettype none
module tlpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/tlpq_ctrl.sv */
`default_nettype none
module tlpq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire tlpq_pkg::dp_stat_type stat,
   output tlpq_pkg::ctrl_cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DECIDE = 4'b0010,
      S_FETCH  = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.command != tlpq_pkg::CMD_SERVICE) begin
               if (stat.tgt_full) begin
                  cmd.drop = 1'b1;
               end else begin
                  cmd.push = 1'b1;
               end
               state_in = S_RESP;
            end else if (!stat.high_empty) begin
               // serving high also ages the middle head up into high
               cmd.pop       = 1'b1;
               cmd.pop_level = tlpq_pkg::LVL_HIGH;
               cmd.promote   = !stat.middle_empty;
               state_in      = S_FETCH;
            end else if (!stat.middle_empty) begin
               cmd.pop       = 1'b1;
               cmd.pop_level = tlpq_pkg::LVL_MIDDLE;
               state_in      = S_FETCH;
            end else if (!stat.low_empty) begin
               cmd.pop       = 1'b1;
               cmd.pop_level = tlpq_pkg::LVL_LOW;
               state_in      = S_FETCH;
            end else begin
               cmd.none_left = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_FETCH: begin
            cmd.capture = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/tlpq_dp.sv */
`default_nettype none
module tlpq_dp #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tlpq_pkg::ctrl_cmd_type cmd,
   output tlpq_pkg::dp_stat_type       stat,
   input  wire logic [1:0]             req_command,
   input  wire logic [15:0]            req_request_id,
   output logic      [1:0]             rsp_status,
   output logic      [15:0]            rsp_served_id,
   output logic      [1:0]             rsp_served_level
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int WIDE_W = (ID_WIDTH > tlpq_pkg::FIELD_ID_W) ? ID_WIDTH : tlpq_pkg::FIELD_ID_W;
   localparam int NL     = tlpq_pkg::NUM_LEVELS;

   logic [1:0]          command_ff;
   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic [1:0]          level_ff;
   logic                promote_ff;
   logic [WIDE_W-1:0]   req_wide, served_wide;

   logic [PTR_W-1:0]    head_ff [NL];
   logic [PTR_W-1:0]    head_in [NL];
   logic [PTR_W-1:0]    tail_ff [NL];
   logic [PTR_W-1:0]    tail_in [NL];
   logic [CNT_W-1:0]    count_ff [NL];
   logic [CNT_W-1:0]    count_in [NL];
   logic                wr_en [NL];
   logic                rd_en [NL];
   logic [ID_WIDTH-1:0] wr_data [NL];
   logic [ID_WIDTH-1:0] rd_data [NL];
   logic [ID_WIDTH-1:0] rd_sel;
   logic                full [NL];

   logic [1:0]  status_ff, status_in;
   logic [15:0] served_id_ff, served_id_in;
   logic [1:0]  served_level_ff, served_level_in;

   assign req_wide = WIDE_W'(req_request_id);
   assign id_in    = req_wide[ID_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= req_command;
         id_ff      <= id_in;
      end
      if (cmd.pop) begin
         level_ff   <= cmd.pop_level;
         promote_ff <= cmd.promote;
      end
   end

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         // request codes equal level numbers
         wr_en[i]   = (cmd.push && command_ff == 2'(i)) ||
                      (cmd.capture && promote_ff && 2'(i) == tlpq_pkg::LVL_HIGH);
         wr_data[i] = cmd.push ? id_ff : rd_data[1];
         rd_en[i]   = cmd.pop && ((cmd.pop_level == 2'(i)) ||
                      (cmd.promote && 2'(i) == tlpq_pkg::LVL_MIDDLE));
         full[i]    = (count_ff[i] == CNT_W'(QUEUE_DEPTH));
         tail_in[i] = tail_ff[i];
         head_in[i] = head_ff[i];
         count_in[i] = count_ff[i];
         if (wr_en[i]) begin
            tail_in[i]  = (tail_ff[i] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff[i] + PTR_W'(1);
            count_in[i] = count_ff[i] + CNT_W'(1);
         end
         if (rd_en[i]) begin
            head_in[i]  = (head_ff[i] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff[i] + PTR_W'(1);
            count_in[i] = count_ff[i] - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NL; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NL; i++) begin
            head_ff[i]  <= head_in[i];
            tail_ff[i]  <= tail_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   for (genvar g = 0; g < NL; g++) begin : g_queue
      tlpq_ram #(
         .WIDTH (ID_WIDTH),
         .DEPTH (QUEUE_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (tail_ff[g]),
         .wr_data (wr_data[g]),
         .rd_en   (rd_en[g]),
         .rd_addr (head_ff[g]),
         .rd_data (rd_data[g])
      );
   end

   always_comb begin
      case (level_ff)
         tlpq_pkg::LVL_HIGH:   rd_sel = rd_data[0];
         tlpq_pkg::LVL_MIDDLE: rd_sel = rd_data[1];
         default:              rd_sel = rd_data[2];
      endcase
   end

   assign served_wide = WIDE_W'(rd_sel);

   always_comb begin
      status_in       = status_ff;
      served_id_in    = served_id_ff;
      served_level_in = served_level_ff;
      if (cmd.push) begin
         status_in       = tlpq_pkg::ST_ACCEPTED;
         served_id_in    = '0;
         served_level_in = tlpq_pkg::LVL_HIGH;
      end else if (cmd.drop) begin
         status_in       = tlpq_pkg::ST_DROPPED;
         served_id_in    = '0;
         served_level_in = tlpq_pkg::LVL_HIGH;
      end else if (cmd.none_left) begin
         status_in       = tlpq_pkg::ST_EMPTY;
         served_id_in    = '0;
         served_level_in = tlpq_pkg::LVL_HIGH;
      end else if (cmd.capture) begin
         status_in       = tlpq_pkg::ST_SERVED;
         served_id_in    = served_wide[tlpq_pkg::FIELD_ID_W-1:0];
         served_level_in = level_ff;
      end
   end

   always_ff @(posedge clock) begin
      status_ff       <= status_in;
      served_id_ff    <= served_id_in;
      served_level_ff <= served_level_in;
   end

   always_comb begin
      stat.command      = command_ff;
      stat.high_empty   = (count_ff[0] == '0);
      stat.middle_empty = (count_ff[1] == '0);
      stat.low_empty    = (count_ff[2] == '0);
      case (command_ff)
         tlpq_pkg::CMD_REQ_HIGH:   stat.tgt_full = full[0];
         tlpq_pkg::CMD_REQ_MIDDLE: stat.tgt_full = full[1];
         tlpq_pkg::CMD_REQ_LOW:    stat.tgt_full = full[2];
         default:                  stat.tgt_full = 1'b0;
      endcase
   end

   assign rsp_status       = status_ff;
   assign rsp_served_id    = served_id_ff;
   assign rsp_served_level = served_level_ff;

endmodule
`default_nettype wire

/* test/tlpq_checker.sv */
`default_nettype none
module tlpq_checker #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   tlpq_req_if       req_ch,
   tlpq_rsp_if       rsp_ch,
   output int        fail_count,
   output int        pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]                      status;
      logic [tlpq_pkg::FIELD_ID_W-1:0] served_id;
      logic [1:0]                      served_level;
   } outcome_type;

   // shadow copies of the three queues, head at index 0
   logic [ID_WIDTH-1:0] high_ids[$];
   logic [ID_WIDTH-1:0] middle_ids[$];
   logic [ID_WIDTH-1:0] low_ids[$];

   outcome_type outcome_fifo[$];

   function automatic outcome_type serve_or_queue(logic [1:0] cmd,
                                                  logic [tlpq_pkg::FIELD_ID_W-1:0] rid);
      logic [ID_WIDTH-1:0] id_kept;
      outcome_type         o;
      id_kept = ID_WIDTH'(rid);
      o = '{status: tlpq_pkg::ST_EMPTY, served_id: '0, served_level: tlpq_pkg::LVL_HIGH};
      case (cmd)
         tlpq_pkg::CMD_REQ_HIGH: begin
            if (high_ids.size() < QUEUE_DEPTH) begin
               high_ids.push_back(id_kept);
               o.status = tlpq_pkg::ST_ACCEPTED;
            end else begin
               o.status = tlpq_pkg::ST_DROPPED;
            end
         end
         tlpq_pkg::CMD_REQ_MIDDLE: begin
            if (middle_ids.size() < QUEUE_DEPTH) begin
               middle_ids.push_back(id_kept);
               o.status = tlpq_pkg::ST_ACCEPTED;
            end else begin
               o.status = tlpq_pkg::ST_DROPPED;
            end
         end
         tlpq_pkg::CMD_REQ_LOW: begin
            if (low_ids.size() < QUEUE_DEPTH) begin
               low_ids.push_back(id_kept);
               o.status = tlpq_pkg::ST_ACCEPTED;
            end else begin
               o.status = tlpq_pkg::ST_DROPPED;
            end
         end
         tlpq_pkg::CMD_SERVICE: begin
            if (high_ids.size() > 0) begin
               o.served_id    = tlpq_pkg::FIELD_ID_W'(high_ids.pop_front());
               o.served_level = tlpq_pkg::LVL_HIGH;
               o.status       = tlpq_pkg::ST_SERVED;
               // aging: middle head moves up into the slot just freed
               if (middle_ids.size() > 0) begin
                  high_ids.push_back(middle_ids.pop_front());
               end
            end else if (middle_ids.size() > 0) begin
               o.served_id    = tlpq_pkg::FIELD_ID_W'(middle_ids.pop_front());
               o.served_level = tlpq_pkg::LVL_MIDDLE;
               o.status       = tlpq_pkg::ST_SERVED;
            end else if (low_ids.size() > 0) begin
               o.served_id    = tlpq_pkg::FIELD_ID_W'(low_ids.pop_front());
               o.served_level = tlpq_pkg::LVL_LOW;
               o.status       = tlpq_pkg::ST_SERVED;
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   always @(posedge clock) begin : watch
      int          bad;
      outcome_type want;
      bad = 0;
      if (reset) begin
         high_ids.delete();
         middle_ids.delete();
         low_ids.delete();
         outcome_fifo.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         // result first: its expectation was queued at an earlier edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outcome_fifo.size() == 0) begin
               $error("result word with nothing expected: status %0d served_id %0h level %0d",
                      rsp_ch.status, rsp_ch.served_id, rsp_ch.served_level);
               bad++;
            end else begin
               want = outcome_fifo.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_ch.status);
                  bad++;
               end
               if (rsp_ch.served_id !== want.served_id) begin
                  $error("served_id expected %0h actual %0h", want.served_id, rsp_ch.served_id);
                  bad++;
               end
               if (rsp_ch.served_level !== want.served_level) begin
                  $error("served_level expected %0d actual %0d", want.served_level,
                         rsp_ch.served_level);
                  bad++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            outcome_fifo.push_back(serve_or_queue(req_ch.command, req_ch.request_id));
         end
         fail_count    <= fail_count + bad;
         pending_count <= outcome_fifo.size();
      end
   end

endmodule
`default_nettype wire

/* test/tb_top.sv */
`default_nettype none
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 2000;
   localparam int IDLE_LIMIT   = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   idle_cycles;

   tlpq_req_if req_ch ();
   tlpq_rsp_if rsp_ch ();

   three_level_priority_queue_promote_core #(
      .QUEUE_DEPTH(16),
      .ID_WIDTH   (16)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   tlpq_checker #(
      .QUEUE_DEPTH(16),
      .ID_WIDTH   (16)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // no handshake on either side for too long means the core is stuck
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // receiver back-pressure, switches among four randomly picked ready patterns
   initial begin : rsp_stall
      int   mode;
      int   cyc;
      int   hold_left;
      logic rdy;
      mode      = 0;
      cyc       = 0;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 300 == 0) begin
            mode = $urandom_range(0, 3);
         end
         case (mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = (cyc % 3 == 0);
            default: begin
               if (hold_left > 0) begin
                  hold_left--;
                  rdy = 1'b0;
               end else begin
                  rdy       = 1'b1;
                  hold_left = $urandom_range(0, 15);
               end
            end
         endcase
         rsp_ch.ready <= rdy;
      end
   end

   task automatic send_word(logic [1:0] cmd, logic [tlpq_pkg::FIELD_ID_W-1:0] rid);
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.request_id <= rid;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic idle_for(int cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic logic [1:0] pick_request();
      case ($urandom_range(0, 2))
         0: return tlpq_pkg::CMD_REQ_HIGH;
         1: return tlpq_pkg::CMD_REQ_MIDDLE;
         default: return tlpq_pkg::CMD_REQ_LOW;
      endcase
   endfunction

   function automatic logic [1:0] pick_command(int bias);
      int r;
      r = $urandom_range(0, 9);
      case (bias)
         0: return (r < 8) ? pick_request() : tlpq_pkg::CMD_SERVICE;   // filling
         1: return (r < 8) ? tlpq_pkg::CMD_SERVICE : pick_request();   // draining
         default: return (r < 3) ? tlpq_pkg::CMD_SERVICE : pick_request();
      endcase
   endfunction

   function automatic logic [tlpq_pkg::FIELD_ID_W-1:0] pick_id();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return tlpq_pkg::FIELD_ID_W'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin : stimulus
      int sent;
      int bias;
      int phase_left;
      int burst;
      int gap;
      req_ch.valid      = 1'b0;
      req_ch.command    = tlpq_pkg::CMD_SERVICE;
      req_ch.request_id = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty service, promotion, fall-through, full queue
      send_word(tlpq_pkg::CMD_SERVICE, 16'h1234);
      send_word(tlpq_pkg::CMD_REQ_HIGH, 16'hFFFF);
      send_word(tlpq_pkg::CMD_REQ_MIDDLE, 16'h0000);
      send_word(tlpq_pkg::CMD_REQ_LOW, 16'h5555);
      send_word(tlpq_pkg::CMD_SERVICE, 16'h0000);
      send_word(tlpq_pkg::CMD_SERVICE, 16'hFFFF);
      send_word(tlpq_pkg::CMD_SERVICE, 16'h0000);
      send_word(tlpq_pkg::CMD_REQ_MIDDLE, 16'h8001);
      send_word(tlpq_pkg::CMD_SERVICE, 16'h7FFE);
      for (int i = 0; i < 17; i++) begin
         send_word(tlpq_pkg::CMD_REQ_LOW, 16'hA5A5 ^ 16'(i));
      end
      wait_drained();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         bias       = $urandom_range(0, 2);
         phase_left = $urandom_range(20, 150);
         while (phase_left > 0 && sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
            repeat (burst) begin
               send_word(pick_command(bias), pick_id());
               sent++;
               phase_left--;
            end
            if ($urandom_range(0, 30) == 0) begin
               wait_drained();
            end else begin
               case ($urandom_range(0, 9))
                  0, 1, 2: gap = 0;
                  3:       gap = $urandom_range(10, 30);
                  default: gap = $urandom_range(1, 6);
               endcase
               if (gap > 0) begin
                  idle_for(gap);
               end
            end
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
